@@ hw/rtl/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Widths and constants shared by the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    // coordinates and differences
    localparam int COORD_W  = 24;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int SUM_W    = PROD_W + 1;

    // cross product magnitude is split in two halves for squaring
    localparam int HALF_W   = DIFF_W;
    localparam int MAG_W    = 2 * HALF_W;
    localparam int C2_W     = 2 * MAG_W;

    // squared distance quotient and distance
    localparam int QD_W     = PROD_W;
    localparam int DIST_W   = QD_W / 2;

    // direction
    localparam int DIR_FRAC = 14;
    localparam int DIR_W    = DIR_FRAC + 2;
    localparam int DIR_Q_W  = DIR_FRAC + 2;
    localparam int NSQ_IN_W = ((SUM_W + 2 * DIR_FRAC + 1) / 2) * 2;
    localparam int N_W      = NSQ_IN_W / 2;
    localparam int DNUM_W   = N_W + DIR_Q_W;

    // configuration
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_X,
        REG_START_Y,
        REG_END_X,
        REG_END_Y
    } t_cfg_reg;

endpackage

@@ hw/rtl/psd_div.sv @@
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels along. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module psd_div #(
    parameter int NW = 100,
    parameter int DW = 50,
    parameter int QW = 50,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [QW];
    logic [QW-1:0] r_sh   [QW];
    logic [SW-1:0] r_side [QW];
    logic [DW-1:0] r_rem  [QW-1];
    logic [DW-1:0] r_den  [QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          vld_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] sh_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          q_bit;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = DW'(i_num[NW-1:QW]);
            assign den_in  = i_den;
            assign sh_in   = i_num[QW-1:0];
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign sh_in   = r_sh[k-1];
            assign side_in = r_side[k-1];
        end

        // shift in the next numerator bit, subtract when it fits
        assign trial = {rem_in, sh_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};
        assign q_bit = (trial >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sh[k]   <= (sh_in << 1) | QW'(q_bit);
                r_side[k] <= side_in;
            end
        end

        if (k < QW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= q_bit ? diff[DW-1:0] : trial[DW-1:0];
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_sh[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

@@ hw/rtl/psd_sqrt.sv @@
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined integer square root, one root bit per stage, floor result,
// with a sideband that travels along.
// ----------------------------------------------------------------------------
module psd_sqrt #(
    parameter int IW = 50,
    parameter int SW = 1,
    parameter int OW = IW / 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [IW-1:0] i_x,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [OW-1:0] o_root,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [OW];
    logic [OW-1:0] r_root [OW];
    logic [SW-1:0] r_side [OW];
    logic [OW:0]   r_rem  [OW-1];
    logic [IW-1:0] r_x    [OW-1];

    for (genvar k = 0; k < OW; k++) begin : g_stage
        logic          vld_in;
        logic [OW:0]   rem_in;
        logic [OW-1:0] root_in;
        logic [IW-1:0] x_in;
        logic [SW-1:0] side_in;
        logic [OW+1:0] trial;
        logic [OW+1:0] tst;
        logic [OW+1:0] diff;
        logic          r_bit;

        if (k == 0) begin : g_first
            assign vld_in  = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign x_in    = i_x;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign x_in    = r_x[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down two bits, try root*4 + 1
        assign trial = {rem_in[OW-1:0], x_in[IW-1 -: 2]};
        assign tst   = {root_in, 2'b01};
        assign diff  = trial - tst;
        assign r_bit = (trial >= tst);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= (root_in << 1) | OW'(r_bit);
                r_side[k] <= side_in;
            end
        end

        if (k < OW - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= r_bit ? diff[OW:0] : trial[OW:0];
                    r_x[k]   <= x_in << 2;
                end
            end
        end
    end

    assign o_valid = r_vld[OW-1];
    assign o_root  = r_root[OW-1];
    assign o_side  = r_side[OW-1];

endmodule

@@ hw/rtl/point_segment_distance.sv @@
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a query point to a configured segment and the unit vector
// from the nearest segment point toward the query point.
// ----------------------------------------------------------------------------
// Usage:
//   Write the segment ends (start x, start y, end x, end y, indexes 0 to 3)
//   on the cfg channel while no item is in flight; o_cfg_ready is always high.
//   Items enter on i_in_valid / o_in_stall with i_point_x, i_point_y (Q15.8)
//   and leave on o_out_valid / i_out_stall with o_dist_res (unsigned, 8
//   fraction bits) and o_dir_x, o_dir_y (Q1.14).
//   Throughput is one item per cycle unless a result is held. There are six
//   front stages for differences, products and case selection, 50 stages of
//   the squared distance divider, 25 of the distance root, 40 of the norm root,
//   one to set up the direction dividers, 16 of those dividers and the output
//   stage. The whole pipeline moves as one; when a result waits on i_out_stall
//   every stage holds and o_in_stall rises in the same cycle. Reset clears all
//   valid bits and the segment registers to zero.
// ----------------------------------------------------------------------------
module point_segment_distance
    import psd_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COORD_W-1:0]          i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic signed [COORD_W-1:0]   i_point_x,
    input  logic signed [COORD_W-1:0]   i_point_y,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [DIST_W-1:0]           o_dist_res,
    output logic signed [DIR_W-1:0]     o_dir_x,
    output logic signed [DIR_W-1:0]     o_dir_y
);

    localparam int SIDE1_W = 3 + 2 * DIFF_W + SUM_W;
    localparam int SIDE3_W = DIST_W + 3 + 2 * DIFF_W;
    localparam int SIDEA_W = DIST_W + 2;
    localparam logic [DIR_Q_W-1:0] DIR_LIM = DIR_Q_W'(1) << DIR_FRAC;

    function automatic logic [DIFF_W-1:0] mag_d(input logic signed [DIFF_W-1:0] v);
        mag_d = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    logic en;

    // ------------------------------------------------------------ config
    logic signed [COORD_W-1:0] r_seg_start_x, r_seg_start_y, r_seg_end_x, r_seg_end_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_start_x <= '0;
            r_seg_start_y <= '0;
            r_seg_end_x   <= '0;
            r_seg_end_y   <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_START_X: r_seg_start_x <= i_cfg_data;
                REG_START_Y: r_seg_start_y <= i_cfg_data;
                REG_END_X:   r_seg_end_x   <= i_cfg_data;
                REG_END_Y:   r_seg_end_y   <= i_cfg_data;
                default:     r_seg_start_x <= r_seg_start_x;
            endcase
        end
    end

    // ------------------------------------------------------------ stage a: differences
    logic                     r_a_valid;
    logic signed [DIFF_W-1:0] r_a_ux, r_a_uy, r_a_dx, r_a_dy, r_a_vx, r_a_vy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_ux <= DIFF_W'(i_point_x) - DIFF_W'(r_seg_start_x);
            r_a_uy <= DIFF_W'(i_point_y) - DIFF_W'(r_seg_start_y);
            r_a_dx <= DIFF_W'(r_seg_end_x) - DIFF_W'(r_seg_start_x);
            r_a_dy <= DIFF_W'(r_seg_end_y) - DIFF_W'(r_seg_start_y);
            r_a_vx <= DIFF_W'(i_point_x) - DIFF_W'(r_seg_end_x);
            r_a_vy <= DIFF_W'(i_point_y) - DIFF_W'(r_seg_end_y);
        end
    end

    // ------------------------------------------------------------ stage b: products
    logic                     r_b_valid;
    logic signed [DIFF_W-1:0] r_b_ux, r_b_uy, r_b_dx, r_b_dy, r_b_vx, r_b_vy;
    logic signed [PROD_W-1:0] r_b_dot1, r_b_dot2, r_b_lx, r_b_ly, r_b_c1, r_b_c2;
    logic signed [PROD_W-1:0] r_b_uxx, r_b_uyy, r_b_vxx, r_b_vyy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ux   <= r_a_ux;
            r_b_uy   <= r_a_uy;
            r_b_dx   <= r_a_dx;
            r_b_dy   <= r_a_dy;
            r_b_vx   <= r_a_vx;
            r_b_vy   <= r_a_vy;
            r_b_dot1 <= r_a_ux * r_a_dx;
            r_b_dot2 <= r_a_uy * r_a_dy;
            r_b_lx   <= r_a_dx * r_a_dx;
            r_b_ly   <= r_a_dy * r_a_dy;
            r_b_c1   <= r_a_dx * r_a_uy;
            r_b_c2   <= r_a_dy * r_a_ux;
            r_b_uxx  <= r_a_ux * r_a_ux;
            r_b_uyy  <= r_a_uy * r_a_uy;
            r_b_vxx  <= r_a_vx * r_a_vx;
            r_b_vyy  <= r_a_vy * r_a_vy;
        end
    end

    // ------------------------------------------------------------ stage c: sums
    logic                     r_c_valid;
    logic signed [DIFF_W-1:0] r_c_ux, r_c_uy, r_c_dx, r_c_dy, r_c_vx, r_c_vy;
    logic signed [SUM_W-1:0]  r_c_dot, r_c_len2, r_c_cross, r_c_su, r_c_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ux    <= r_b_ux;
            r_c_uy    <= r_b_uy;
            r_c_dx    <= r_b_dx;
            r_c_dy    <= r_b_dy;
            r_c_vx    <= r_b_vx;
            r_c_vy    <= r_b_vy;
            r_c_dot   <= SUM_W'(r_b_dot1) + SUM_W'(r_b_dot2);
            r_c_len2  <= SUM_W'(r_b_lx) + SUM_W'(r_b_ly);
            r_c_cross <= SUM_W'(r_b_c1) - SUM_W'(r_b_c2);
            r_c_su    <= SUM_W'(r_b_uxx) + SUM_W'(r_b_uyy);
            r_c_sv    <= SUM_W'(r_b_vxx) + SUM_W'(r_b_vyy);
        end
    end

    // ------------------------------------------------------------ stage d: case selection
    logic                     c_start, c_end, c_perp;
    logic signed [DIFF_W-1:0] c_a, c_b;
    logic signed [SUM_W-1:0]  c_cmag;

    logic                     r_d_valid, r_d_perp, r_d_zero, r_d_sa, r_d_sb;
    logic [SUM_W-1:0]         r_d_s, r_d_len2;
    logic [MAG_W-1:0]         r_d_cmag;
    logic [DIFF_W-1:0]        r_d_ma, r_d_mb;

    always_comb begin
        c_start = (r_c_len2 == '0) || r_c_dot[SUM_W-1];
        c_end   = !c_start && (r_c_dot > r_c_len2);
        c_perp  = !c_start && !c_end;
        c_cmag  = r_c_cross[SUM_W-1] ? -r_c_cross : r_c_cross;
        priority if (c_start) begin
            c_a = r_c_ux;
            c_b = r_c_uy;
        end else if (c_end) begin
            c_a = r_c_vx;
            c_b = r_c_vy;
        end else if (r_c_cross[SUM_W-1]) begin
            c_a = r_c_dy;
            c_b = -r_c_dx;
        end else if (r_c_cross != '0) begin
            c_a = -r_c_dy;
            c_b = r_c_dx;
        end else begin
            c_a = '0;
            c_b = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_perp <= c_perp;
            r_d_zero <= (c_a == '0) && (c_b == '0);
            r_d_sa   <= c_a[DIFF_W-1];
            r_d_sb   <= c_b[DIFF_W-1];
            r_d_ma   <= mag_d(c_a);
            r_d_mb   <= mag_d(c_b);
            r_d_s    <= c_start ? r_c_su : r_c_sv;
            r_d_len2 <= r_c_len2;
            r_d_cmag <= c_cmag[MAG_W-1:0];
        end
    end

    // ------------------------------------------------------------ stage e: partial squares
    logic                     r_e_valid, r_e_perp, r_e_zero, r_e_sa, r_e_sb;
    logic [SUM_W-1:0]         r_e_s, r_e_len2;
    logic [DIFF_W-1:0]        r_e_ma, r_e_mb;
    logic [PROD_W-1:0]        r_e_hh, r_e_hl, r_e_ll, r_e_a2, r_e_b2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (en) begin
            r_e_valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_perp <= r_d_perp;
            r_e_zero <= r_d_zero;
            r_e_sa   <= r_d_sa;
            r_e_sb   <= r_d_sb;
            r_e_ma   <= r_d_ma;
            r_e_mb   <= r_d_mb;
            r_e_s    <= r_d_s;
            r_e_len2 <= r_d_len2;
            r_e_hh   <= r_d_cmag[MAG_W-1:HALF_W] * r_d_cmag[MAG_W-1:HALF_W];
            r_e_hl   <= r_d_cmag[MAG_W-1:HALF_W] * r_d_cmag[HALF_W-1:0];
            r_e_ll   <= r_d_cmag[HALF_W-1:0] * r_d_cmag[HALF_W-1:0];
            r_e_a2   <= r_d_ma * r_d_ma;
            r_e_b2   <= r_d_mb * r_d_mb;
        end
    end

    // ------------------------------------------------------------ stage f: divider operands
    logic                     r_f_valid;
    logic [C2_W-1:0]          r_f_num;
    logic [PROD_W-1:0]        r_f_den;
    logic [SIDE1_W-1:0]       r_f_side;
    logic [C2_W-1:0]          c_c2;

    assign c_c2 = (C2_W'(r_e_hh) << (2 * HALF_W)) + (C2_W'(r_e_hl) << (HALF_W + 1))
                + C2_W'(r_e_ll);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else if (en) begin
            r_f_valid <= r_e_valid;
        end
    end

    // endpoint cases divide the squared distance by one
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_num  <= r_e_perp ? c_c2 : C2_W'(r_e_s[PROD_W-1:0]);
            r_f_den  <= r_e_perp ? r_e_len2[PROD_W-1:0] : PROD_W'(1);
            r_f_side <= {r_e_zero, r_e_sa, r_e_sb, r_e_ma, r_e_mb,
                         SUM_W'(r_e_a2) + SUM_W'(r_e_b2)};
        end
    end

    // ------------------------------------------------------------ distance
    logic                 q_valid;
    logic [QD_W-1:0]      q_dist2;
    logic [SIDE1_W-1:0]   q_side;
    logic                 s_valid;
    logic [DIST_W-1:0]    s_dist;
    logic [SIDE1_W-1:0]   s_side;

    psd_div #(
        .NW(C2_W), .DW(PROD_W), .QW(QD_W), .SW(SIDE1_W)
    ) u_dist_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_f_valid), .i_num(r_f_num), .i_den(r_f_den), .i_side(r_f_side),
        .o_valid(q_valid), .o_quo(q_dist2), .o_side(q_side)
    );

    psd_sqrt #(
        .IW(QD_W), .SW(SIDE1_W), .OW(DIST_W)
    ) u_dist_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(q_valid), .i_x(q_dist2), .i_side(q_side),
        .o_valid(s_valid), .o_root(s_dist), .o_side(s_side)
    );

    // ------------------------------------------------------------ direction norm
    logic                 n_in_zero, n_in_sa, n_in_sb;
    logic [DIFF_W-1:0]    n_in_ma, n_in_mb;
    logic [SUM_W-1:0]     n_in_sdir;
    logic                 n_valid;
    logic [N_W-1:0]       n_norm;
    logic [SIDE3_W-1:0]   n_side;

    assign {n_in_zero, n_in_sa, n_in_sb, n_in_ma, n_in_mb, n_in_sdir} = s_side;

    psd_sqrt #(
        .IW(NSQ_IN_W), .SW(SIDE3_W), .OW(N_W)
    ) u_norm_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_valid),
        .i_x(NSQ_IN_W'({n_in_sdir, {(2 * DIR_FRAC){1'b0}}})),
        .i_side({s_dist, n_in_zero, n_in_sa, n_in_sb, n_in_ma, n_in_mb}),
        .o_valid(n_valid), .o_root(n_norm), .o_side(n_side)
    );

    // ------------------------------------------------------------ stage g: rounded numerators
    logic [DIST_W-1:0]    g_dist;
    logic                 g_zero, g_sa, g_sb;
    logic [DIFF_W-1:0]    g_ma, g_mb;

    logic                 r_g_valid;
    logic [DNUM_W-1:0]    r_g_num_a, r_g_num_b;
    logic [N_W-1:0]       r_g_norm;
    logic [SIDEA_W-1:0]   r_g_side_a;
    logic                 r_g_sb;

    assign {g_dist, g_zero, g_sa, g_sb, g_ma, g_mb} = n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (en) begin
            r_g_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_num_a  <= (DNUM_W'(g_ma) << (2 * DIR_FRAC)) + DNUM_W'(n_norm >> 1);
            r_g_num_b  <= (DNUM_W'(g_mb) << (2 * DIR_FRAC)) + DNUM_W'(n_norm >> 1);
            r_g_norm   <= n_norm;
            r_g_side_a <= {g_dist, g_zero, g_sa};
            r_g_sb     <= g_sb;
        end
    end

    // ------------------------------------------------------------ direction components
    logic                 da_valid, db_valid;
    logic [DIR_Q_W-1:0]   da_q, db_q;
    logic [SIDEA_W-1:0]   da_side;
    logic                 db_sb;

    psd_div #(
        .NW(DNUM_W), .DW(N_W), .QW(DIR_Q_W), .SW(SIDEA_W)
    ) u_dir_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_g_valid), .i_num(r_g_num_a), .i_den(r_g_norm), .i_side(r_g_side_a),
        .o_valid(da_valid), .o_quo(da_q), .o_side(da_side)
    );

    psd_div #(
        .NW(DNUM_W), .DW(N_W), .QW(DIR_Q_W), .SW(1)
    ) u_dir_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(r_g_valid), .i_num(r_g_num_b), .i_den(r_g_norm), .i_side(r_g_sb),
        .o_valid(db_valid), .o_quo(db_q), .o_side(db_sb)
    );

    // ------------------------------------------------------------ stage h: output register
    logic [DIST_W-1:0]    h_dist;
    logic                 h_zero, h_sa;
    logic [DIR_Q_W-1:0]   h_ma, h_mb;

    logic                        r_out_valid;
    logic [DIST_W-1:0]           r_dist_res;
    logic signed [DIR_W-1:0]     r_dir_x, r_dir_y;

    assign {h_dist, h_zero, h_sa} = da_side;
    assign h_ma = (da_q > DIR_LIM) ? DIR_LIM : da_q;
    assign h_mb = (db_q > DIR_LIM) ? DIR_LIM : db_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= da_valid && db_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist_res <= h_dist;
            if (h_zero) begin
                r_dir_x <= '0;
                r_dir_y <= '0;
            end else begin
                r_dir_x <= h_sa  ? -DIR_W'(h_ma) : DIR_W'(h_ma);
                r_dir_y <= db_sb ? -DIR_W'(h_mb) : DIR_W'(h_mb);
            end
        end
    end

    // all stages advance together unless a result is held
    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_out_valid;
    assign o_dist_res  = r_dist_res;
    assign o_dir_x     = r_dir_x;
    assign o_dir_y     = r_dir_y;

    // ------------------------------------------------------------ checks
    localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(DIR_LIM);

    a_dir_x_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dir_x <= DIR_ONE) && (o_dir_x >= -DIR_ONE))
        else $error("dir_x outside unit range");

    a_dir_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_dir_y <= DIR_ONE) && (o_dir_y >= -DIR_ONE))
        else $error("dir_y outside unit range");

    a_zero_dir_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_dir_x == '0) && (o_dir_y == '0)) |-> (o_dist_res == '0))
        else $error("zero direction with nonzero distance");

endmodule
